>>> src/igfr_pkg.sv
`default_nettype none

package igfr_pkg;

  // Input command codes.
  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // Register select codes, taken from paddr[2].
  localparam logic REG_GAP_MS  = 1'b0;
  localparam logic REG_MAX_LEN = 1'b1;

  // Register reset values.
  localparam logic [7:0] GAP_MS_RESET  = 8'd30;
  localparam logic [6:0] MAX_LEN_RESET = 7'd64;

  // Most bytes read out of one frame, whatever the length register holds.
  localparam logic [6:0] MAX_RESULTS = 7'd64;

  // Saturation value of the idle counter.
  localparam logic [7:0] IDLE_MAX = 8'd255;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_FETCH,
    SEQ_SHOW
  } seq_state_t;

  // Readout request from the receive control to the readout sequencer.
  typedef struct packed {
    logic       go;
    logic [6:0] len;
  } start_t;

endpackage

`default_nettype wire

>>> src/igfr_ram.sv
`default_nettype none

module igfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AddrW-1:0] waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AddrW-1:0] raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> src/igfr_seq.sv
`default_nettype none

module igfr_seq (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire igfr_pkg::start_t start,
  input  wire logic            out_stall,
  input  wire logic [7:0]      rdata,
  output logic                 rd_en,
  output logic      [6:0]      rd_idx,
  output logic                 out_valid,
  output logic      [7:0]      out_frame_byte,
  output logic                 out_last,
  output logic      [6:0]      out_len,
  output logic                 busy
);
  import igfr_pkg::*;

  seq_state_t state_r, state_nxt;
  logic [6:0] idx_r, idx_nxt;
  logic [6:0] len_r, len_nxt;
  logic       last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SEQ_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    len_r <= len_nxt;
  end

  assign last = ((idx_r + 7'd1) == len_r);

  // One byte per pass: fetch from the frame store, then hold it on the
  // output until the consumer takes it.
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    len_nxt   = len_r;
    rd_en     = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      SEQ_IDLE: begin
        if (start.go && (start.len != 7'd0)) begin
          len_nxt   = start.len;
          idx_nxt   = 7'd0;
          state_nxt = SEQ_FETCH;
        end
      end
      SEQ_FETCH: begin
        rd_en     = 1'b1;
        state_nxt = SEQ_SHOW;
      end
      SEQ_SHOW: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          if (last) begin
            state_nxt = SEQ_IDLE;
          end else begin
            idx_nxt   = idx_r + 7'd1;
            state_nxt = SEQ_FETCH;
          end
        end
      end
      default: begin
        state_nxt = SEQ_IDLE;
      end
    endcase
  end

  assign rd_idx         = idx_r;
  assign out_frame_byte = rdata;
  assign out_last       = last;
  assign out_len        = len_r;
  assign busy           = (state_r != SEQ_IDLE);

endmodule

`default_nettype wire

>>> src/idle_gap_frame_receiver.sv
// Idle-gap frame receiver.
// The input channel carries one transaction per received serial byte
// (in_cmd = 0, byte in in_rx_byte) or per timer tick (in_cmd = 1, elapsed
// milliseconds in in_tick_ms). Bytes are written into a frame store of
// BUF_DEPTH entries; bytes past the end of the store are dropped. A tick
// advances a saturating idle counter, and once the line has been idle for
// longer than gap_ms the buffered frame is read out on the output channel,
// one transaction per byte, with out_last_of_frame on the final one.
// A byte or a tick that ends no frame is handled in the cycle it is accepted,
// and in_stall stays low. A tick that ends a frame of N bytes raises in_stall
// for the readout: each byte is read from the frame store, whose data is
// registered, and is then shown on the output.
// Reset clears the counters and the receiving flag and loads gap_ms = 30 and
// max_frame_len = 64; the frame store is not cleared. While out_stall is high
// the current byte holds on the output and the readout waits. Registers are
// written through the APB port at addresses 0 (gap_ms) and 4 (max_frame_len)
// only while the block is idle; this binds the user, and the block itself
// does not enforce it.
`default_nettype none

module idle_gap_frame_receiver #(
  parameter int BUF_DEPTH = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input channel.
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_cmd,
  input  wire logic [7:0]  in_rx_byte,
  input  wire logic [7:0]  in_tick_ms,
  // Output channel.
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic      [7:0]  out_frame_byte,
  output logic             out_last_of_frame,
  output logic      [6:0]  out_frame_length,
  // Configuration port.
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);
  import igfr_pkg::*;

  localparam int AddrW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
  localparam int CntW  = $clog2(BUF_DEPTH + 1);
  localparam int CmpW  = (CntW > 7) ? CntW : 7;

  // Configuration registers.
  logic [7:0] gap_ms_r;
  logic [6:0] max_len_r;
  logic       cfg_wr;

  // Receive state.
  logic [CntW-1:0] byte_count_r, byte_count_nxt;
  logic [CntW-1:0] count_tick_r, count_tick_nxt;
  logic [7:0]      idle_ms_r, idle_ms_nxt;
  logic            receiving_r, receiving_nxt;

  logic            in_accept;
  logic            busy;
  logic            store_we;
  logic [8:0]      idle_sum;
  logic [7:0]      idle_sat;
  logic [7:0]      idle_chk;
  logic [6:0]      len_lim;
  logic [CmpW-1:0] count_ext;
  logic [CmpW-1:0] lim_ext;
  logic [CmpW-1:0] frame_n;
  start_t          start;

  logic            rd_en;
  logic [6:0]      rd_idx;
  logic [7:0]      rdata;

  // ---------------------------------------------------------------------
  // Configuration port. Writes complete in the access phase; pready is
  // tied high so no transaction is ever extended by wait states.
  // ---------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_ms_r  <= GAP_MS_RESET;
      max_len_r <= MAX_LEN_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_GAP_MS:  gap_ms_r  <= pwdata[7:0];
        REG_MAX_LEN: max_len_r <= pwdata[6:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_GAP_MS:  prdata = {24'd0, gap_ms_r};
      REG_MAX_LEN: prdata = {25'd0, max_len_r};
      default:     prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Receive control. Bytes and ticks are handled in the cycle they are
  // accepted; only a frame readout keeps the input stalled.
  // ---------------------------------------------------------------------
  assign in_stall  = busy;
  assign in_accept = in_valid && !in_stall;

  // Saturating idle counter update.
  assign idle_sum = {1'b0, idle_ms_r} + {1'b0, in_tick_ms};
  assign idle_sat = idle_sum[8] ? IDLE_MAX : idle_sum[7:0];

  // A change in byte count since the last tick means the line was active,
  // so the idle time restarts from zero.
  assign idle_chk = (byte_count_r != count_tick_r) ? 8'd0 : idle_sat;

  // Frame length is the buffered count capped by the length register, and
  // that cap is itself limited to MAX_RESULTS bytes.
  assign len_lim   = (max_len_r > MAX_RESULTS) ? MAX_RESULTS : max_len_r;
  assign count_ext = CmpW'(byte_count_r);
  assign lim_ext   = CmpW'(len_lim);
  assign frame_n   = (count_ext < lim_ext) ? count_ext : lim_ext;

  assign store_we = in_accept && (in_cmd == CMD_BYTE) &&
                    (byte_count_r < CntW'(BUF_DEPTH));

  always_comb begin
    byte_count_nxt = byte_count_r;
    count_tick_nxt = count_tick_r;
    idle_ms_nxt    = idle_ms_r;
    receiving_nxt  = receiving_r;
    start.go       = 1'b0;
    start.len      = frame_n[6:0];
    if (in_accept) begin
      case (in_cmd)
        CMD_BYTE: begin
          if (store_we) begin
            byte_count_nxt = byte_count_r + CntW'(1);
          end
          receiving_nxt = 1'b1;
        end
        CMD_TICK: begin
          if (!receiving_r) begin
            idle_ms_nxt = idle_sat;
          end else begin
            count_tick_nxt = byte_count_r;
            if (idle_chk > gap_ms_r) begin
              // Gap exceeded: the frame ends and its bytes go out.
              idle_ms_nxt    = 8'd0;
              receiving_nxt  = 1'b0;
              byte_count_nxt = '0;
              start.go       = 1'b1;
            end else begin
              idle_ms_nxt = idle_chk;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r <= '0;
      count_tick_r <= '0;
      idle_ms_r    <= 8'd0;
      receiving_r  <= 1'b0;
    end else begin
      byte_count_r <= byte_count_nxt;
      count_tick_r <= count_tick_nxt;
      idle_ms_r    <= idle_ms_nxt;
      receiving_r  <= receiving_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Frame store and readout sequencer. The store is written by bytes and
  // read only by the sequencer, which runs while the input is stalled.
  // ---------------------------------------------------------------------
  igfr_ram #(
    .WIDTH (8),
    .DEPTH (BUF_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (byte_count_r[AddrW-1:0]),
    .wdata (in_rx_byte),
    .re    (rd_en),
    .raddr (AddrW'(rd_idx)),
    .rdata (rdata)
  );

  igfr_seq u_seq (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .out_stall      (out_stall),
    .rdata          (rdata),
    .rd_en          (rd_en),
    .rd_idx         (rd_idx),
    .out_valid      (out_valid),
    .out_frame_byte (out_frame_byte),
    .out_last       (out_last_of_frame),
    .out_len        (out_frame_length),
    .busy           (busy)
  );

  // ---------------------------------------------------------------------
  // Checks.
  // ---------------------------------------------------------------------

  // No new transaction is taken while a frame is being read out.
  a_stall_during_readout: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input accepted during frame readout");

  // The byte count never passes the store depth.
  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    byte_count_r <= CntW'(BUF_DEPTH))
    else $error("byte count beyond store depth");

  // During readout the frame has been closed and the count cleared.
  a_frame_closed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (byte_count_r == '0) && !receiving_r && (idle_ms_r == 8'd0))
    else $error("readout with receive state not cleared");

  // Once the last byte of a frame is taken, the output goes quiet.
  a_last_ends_readout: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_of_frame && !out_stall |=> !out_valid)
    else $error("output continued after last byte of frame");

endmodule

`default_nettype wire
